/* rtl/ssd_pkg.sv */
package ssd_pkg;

    localparam int unsigned IN_BITS    = 16;
    localparam int unsigned DEV_BITS   = 20;
    localparam int unsigned CNT_BITS   = 8;
    localparam int unsigned FRAC_SHIFT = 8;

    localparam logic [DEV_BITS-1:0] DEV_MAX = '1;

    typedef struct packed {
        logic signed [IN_BITS-1:0] sample;
        logic                      last;
    } t_in_item;

    typedef struct packed {
        logic [DEV_BITS-1:0] deviation;
        logic [CNT_BITS-1:0] sample_count;
        logic                overflow;
    } t_out_item;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MULT,
        B_SUB,
        B_DIV,
        B_SQRT,
        B_DONE
    } t_back_state;

endpackage

/* rtl/ssd_stream_if.sv */
interface ssd_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/ssd_front.sv */
module ssd_front #(
    parameter int unsigned MAX_SAMPLES = 255,
    parameter int unsigned SAMPLE_BITS = 16,
    parameter int unsigned EW          = 73
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ssd_stream_if.sink      i_in,
    input  logic            i_full,
    output logic            o_push,
    output logic [EW-1:0]   o_wdata
);

    localparam int unsigned XW = (SAMPLE_BITS <= ssd_pkg::IN_BITS) ?
                                 SAMPLE_BITS : ssd_pkg::IN_BITS + 1;
    localparam int unsigned SW = XW + ssd_pkg::CNT_BITS;
    localparam int unsigned QW = 2 * XW + ssd_pkg::CNT_BITS - 1;

    logic [ssd_pkg::CNT_BITS-1:0] r_cnt, n_cnt;
    logic signed [SW-1:0]         r_sum, n_sum;
    logic [QW-1:0]                r_sq, n_sq;
    logic                         r_drop, n_drop;

    logic signed [XW-1:0]         x;
    logic signed [2*XW-1:0]       x_sq;
    logic                         take;
    logic                         accept;

    generate
        if (SAMPLE_BITS <= ssd_pkg::IN_BITS) begin : g_narrow
            assign x = i_in.data.sample[XW-1:0];
        end else begin : g_wide
            assign x = {1'b0, i_in.data.sample};
        end
    endgenerate

    assign x_sq   = x * x;
    assign take   = r_cnt < ssd_pkg::CNT_BITS'(MAX_SAMPLES);
    assign accept = i_in.valid && i_in.ready;

    assign i_in.ready = !i_full;

    always_comb begin
        n_cnt  = take ? r_cnt + 1'b1 : r_cnt;
        n_sum  = take ? r_sum + SW'(x) : r_sum;
        n_sq   = take ? r_sq + QW'($unsigned(x_sq)) : r_sq;
        n_drop = r_drop | ~take;
    end

    assign o_push  = accept && i_in.data.last;
    assign o_wdata = {n_cnt, n_sum, n_sq, n_drop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_sum  <= '0;
            r_sq   <= '0;
            r_drop <= 1'b0;
        end else if (accept) begin
            if (i_in.data.last) begin
                r_cnt  <= '0;
                r_sum  <= '0;
                r_sq   <= '0;
                r_drop <= 1'b0;
            end else begin
                r_cnt  <= n_cnt;
                r_sum  <= n_sum;
                r_sq   <= n_sq;
                r_drop <= n_drop;
            end
        end
    end

endmodule

/* rtl/ssd_queue.sv */
module ssd_queue #(
    parameter int unsigned EW = 73
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [EW-1:0] i_wdata,
    output logic          o_full,
    input  logic          i_pop,
    output logic [EW-1:0] o_rdata,
    output logic          o_empty
);

    logic [EW-1:0] r_mem [2];
    logic          r_wptr;
    logic          r_rptr;
    logic [1:0]    r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

/* rtl/ssd_back.sv */
module ssd_back #(
    parameter int unsigned SAMPLE_BITS = 16,
    parameter int unsigned EW          = 73
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [EW-1:0] i_rdata,
    input  logic          i_empty,
    output logic          o_pop,
    ssd_stream_if.source  o_out
);

    localparam int unsigned CB  = ssd_pkg::CNT_BITS;
    localparam int unsigned XW  = (SAMPLE_BITS <= ssd_pkg::IN_BITS) ?
                                  SAMPLE_BITS : ssd_pkg::IN_BITS + 1;
    localparam int unsigned SW  = XW + CB;
    localparam int unsigned QW  = 2 * XW + CB - 1;
    localparam int unsigned NW  = QW + CB;
    localparam int unsigned PW  = 2 * SW;
    localparam int unsigned MW  = (PW > NW) ? PW : NW;
    localparam int unsigned I   = (NW + ssd_pkg::FRAC_SHIFT + 1) / 2;
    localparam int unsigned VW  = 2 * I;
    localparam int unsigned CW  = $clog2(VW);
    localparam int unsigned RMW = I + 2;
    localparam int unsigned DW  = 2 * CB;
    localparam int unsigned RW  = (I > ssd_pkg::DEV_BITS) ? I : ssd_pkg::DEV_BITS;

    ssd_pkg::t_back_state r_state, n_state;

    logic [CW-1:0]  r_cnt;
    logic [CB-1:0]  r_n;
    logic           r_drop;
    logic [SW-1:0]  r_mag;
    logic [PW-1:0]  r_sq;
    logic [NW-1:0]  r_mcand;
    logic [CB-1:0]  r_mplier;
    logic [NW-1:0]  r_prod;
    logic [DW-1:0]  r_den;
    logic [DW-1:0]  r_rem;
    logic [RMW-1:0] r_srem;
    logic [I-1:0]   r_root;
    logic [VW-1:0]  r_quo;

    logic [CB-1:0]        q_cnt;
    logic signed [SW-1:0] q_sum;
    logic [QW-1:0]        q_sq;
    logic                 q_drop;

    logic [MW-1:0]  prod_ext, sq_ext;
    logic [NW-1:0]  num;
    logic [DW:0]    dt, dden;
    logic           dge;
    logic [RMW+1:0] st, trial;
    logic           sge;
    logic [RW-1:0]  root_ext;

    assign {q_cnt, q_sum, q_sq, q_drop} = i_rdata;

    assign prod_ext = MW'(r_prod);
    assign sq_ext   = MW'(r_sq);
    assign num      = (prod_ext >= sq_ext) ? NW'(prod_ext - sq_ext) : '0;

    assign dt    = {r_rem, r_quo[VW-1]};
    assign dden  = {1'b0, r_den};
    assign dge   = dt >= dden;

    assign st    = {r_srem, r_quo[VW-1 -: 2]};
    assign trial = (RMW + 2)'({r_root, 2'b01});
    assign sge   = st >= trial;

    assign root_ext = RW'(r_root);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ssd_pkg::B_IDLE: begin
                if (!i_empty) begin
                    n_state = (q_cnt < CB'(2)) ? ssd_pkg::B_DONE : ssd_pkg::B_MULT;
                end
            end
            ssd_pkg::B_MULT: begin
                if (r_cnt == CW'(CB - 1)) begin
                    n_state = ssd_pkg::B_SUB;
                end
            end
            ssd_pkg::B_SUB: begin
                n_state = ssd_pkg::B_DIV;
            end
            ssd_pkg::B_DIV: begin
                if (r_cnt == CW'(VW - 1)) begin
                    n_state = ssd_pkg::B_SQRT;
                end
            end
            ssd_pkg::B_SQRT: begin
                if (r_cnt == CW'(I - 1)) begin
                    n_state = ssd_pkg::B_DONE;
                end
            end
            ssd_pkg::B_DONE: begin
                if (o_out.ready) begin
                    n_state = ssd_pkg::B_IDLE;
                end
            end
            default: n_state = ssd_pkg::B_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop       = (r_state == ssd_pkg::B_IDLE) && !i_empty;
        o_out.valid = r_state == ssd_pkg::B_DONE;
        o_out.data.deviation = (root_ext > RW'(ssd_pkg::DEV_MAX)) ?
                               ssd_pkg::DEV_MAX : root_ext[ssd_pkg::DEV_BITS-1:0];
        o_out.data.sample_count = r_n;
        o_out.data.overflow     = r_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssd_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ssd_pkg::B_IDLE: begin
                r_n      <= q_cnt;
                r_drop   <= q_drop;
                r_mag    <= q_sum[SW-1] ? $unsigned(-q_sum) : $unsigned(q_sum);
                r_mcand  <= NW'(q_sq);
                r_mplier <= q_cnt;
                r_prod   <= '0;
                r_den    <= DW'(q_cnt) * (DW'(q_cnt) - DW'(1));
                r_root   <= '0;
                r_cnt    <= '0;
            end
            ssd_pkg::B_MULT: begin
                if (r_mplier[0]) begin
                    r_prod <= r_prod + r_mcand;
                end
                r_mcand  <= {r_mcand[NW-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[CB-1:1]};
                r_sq     <= PW'(r_mag) * PW'(r_mag);
                r_cnt    <= r_cnt + 1'b1;
            end
            ssd_pkg::B_SUB: begin
                r_quo <= VW'({num, ssd_pkg::FRAC_SHIFT'(0)});
                r_rem <= '0;
                r_cnt <= '0;
            end
            ssd_pkg::B_DIV: begin
                r_rem  <= dge ? DW'(dt - dden) : dt[DW-1:0];
                r_quo  <= {r_quo[VW-2:0], dge};
                r_srem <= '0;
                r_root <= '0;
                r_cnt  <= (r_cnt == CW'(VW - 1)) ? '0 : r_cnt + 1'b1;
            end
            ssd_pkg::B_SQRT: begin
                r_srem <= sge ? RMW'(st - trial) : RMW'(st);
                r_root <= {r_root[I-2:0], sge};
                r_quo  <= {r_quo[VW-3:0], 2'b00};
                r_cnt  <= r_cnt + 1'b1;
            end
            ssd_pkg::B_DONE: begin
                r_cnt <= '0;
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssd_pkg::B_DIV) |-> (r_rem < r_den))
        else $error("division remainder not below divisor");

    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssd_pkg::B_SQRT) |-> ((RMW + 1)'(r_srem) <= (RMW + 1)'({r_root, 1'b0})))
        else $error("root remainder above twice the partial root");

    a_small_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (r_n < CB'(2))) |-> (o_out.data.deviation == '0))
        else $error("set of one sample gives nonzero deviation");

    a_pop_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state != ssd_pkg::B_IDLE))
        else $error("back end stayed idle after taking a set");
`endif

endmodule

/* rtl/sample_standard_deviation.sv */
// Sample standard deviation of sets of signed sensor samples, one sample per item, the
// last item of a set marked. The front end accumulates count, sum and sum of squares
// exactly and takes one item every cycle while the queue is not full. A finished set
// moves to a two-entry queue; the back end then picks up the set and works out
// floor(sqrt(256*(n*S2 - S1^2) / (n*(n-1)))) one set at a time with a shift-add
// multiply, a restoring divide (one bit a cycle) and a digit-by-digit square root
// (one bit a cycle), then waits for the result to be taken. Input stalls only while
// the queue holds two finished sets. A set of one sample gives 0. Samples beyond
// MAX_SAMPLES are dropped and reported through overflow.
module sample_standard_deviation #(
    parameter int unsigned MAX_SAMPLES = 255,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ssd_stream_if.sink   i_in,
    ssd_stream_if.source o_out
);

    localparam int unsigned XW = (SAMPLE_BITS <= ssd_pkg::IN_BITS) ?
                                 SAMPLE_BITS : ssd_pkg::IN_BITS + 1;
    localparam int unsigned SW = XW + ssd_pkg::CNT_BITS;
    localparam int unsigned QW = 2 * XW + ssd_pkg::CNT_BITS - 1;
    localparam int unsigned EW = ssd_pkg::CNT_BITS + SW + QW + 1;

    logic          push, pop, full, empty;
    logic [EW-1:0] wdata, rdata;

    ssd_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .EW          (EW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_wdata (wdata)
    );

    ssd_queue #(
        .EW (EW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (wdata),
        .o_full  (full),
        .i_pop   (pop),
        .o_rdata (rdata),
        .o_empty (empty)
    );

    ssd_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .EW          (EW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rdata (rdata),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

/* verif/sample_standard_deviation_checker.sv */
`timescale 1ns / 100ps

module sample_standard_deviation_checker #(
    parameter int unsigned MAX_SAMPLES = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  ssd_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  ssd_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_outstanding
);

    logic [ssd_pkg::CNT_BITS-1:0] set_count;
    logic signed [23:0]           set_sum;
    logic [38:0]                  set_square_sum;
    logic                         set_dropped;
    ssd_pkg::t_out_item           expected_results[$];
    int                           mismatches;

    function automatic logic [31:0] root_floor(input logic [63:0] v);
        logic [31:0] r;
        logic [31:0] trial;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = r | (32'd1 << b);
            if (64'(trial) * 64'(trial) <= v) begin
                r = trial;
            end
        end
        return r;
    endfunction

    function automatic ssd_pkg::t_out_item finish_set(
        input logic [ssd_pkg::CNT_BITS-1:0] count,
        input logic signed [23:0]           sum,
        input logic [38:0]                  square_sum,
        input logic                         dropped
    );
        logic signed [63:0] wide_sum;
        logic [63:0]        n;
        logic [63:0]        mag;
        logic [63:0]        num;
        logic [63:0]        den;
        logic [63:0]        quot;
        logic [63:0]        rem;
        logic [63:0]        scaled;
        logic [31:0]        root;
        ssd_pkg::t_out_item res;
        res.sample_count = count;
        res.overflow     = dropped;
        res.deviation    = '0;
        if (count >= 2) begin
            wide_sum = sum;
            mag      = (wide_sum < 0) ? 64'(-wide_sum) : 64'(wide_sum);
            n        = 64'(count);
            num      = n * 64'(square_sum);
            num      = (num >= mag * mag) ? num - mag * mag : 64'd0;
            den      = n * (n - 64'd1);
            quot     = num / den;
            rem      = num % den;
            scaled   = (quot << ssd_pkg::FRAC_SHIFT) + ((rem << ssd_pkg::FRAC_SHIFT) / den);
            root     = root_floor(scaled);
            res.deviation = (64'(root) > 64'(ssd_pkg::DEV_MAX)) ?
                            ssd_pkg::DEV_MAX : root[ssd_pkg::DEV_BITS-1:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input ssd_pkg::t_out_item want,
                                   input ssd_pkg::t_out_item got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t mismatch: expected dev=%0d cnt=%0d ovf=%0d,",
                     $realtime, want.deviation, want.sample_count, want.overflow,
                     " got dev=%0d cnt=%0d ovf=%0d",
                     got.deviation, got.sample_count, got.overflow);
        end
    endtask

    always @(posedge i_clk) begin
        ssd_pkg::t_out_item want;
        logic signed [31:0] x;
        logic signed [31:0] x_sq;
        if (!i_rst_n) begin
            set_count      = '0;
            set_sum        = '0;
            set_square_sum = '0;
            set_dropped    = 1'b0;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t unexpected result: dev=%0d cnt=%0d ovf=%0d", $realtime,
                                 i_out_data.deviation, i_out_data.sample_count,
                                 i_out_data.overflow);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (want.deviation !== i_out_data.deviation
                        || want.sample_count !== i_out_data.sample_count
                        || want.overflow !== i_out_data.overflow) begin
                        report_mismatch(want, i_out_data);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                x = i_in_data.sample;
                if (set_count < MAX_SAMPLES) begin
                    x_sq           = x * x;
                    set_count      = set_count + 1'b1;
                    set_sum        = set_sum + 24'(x);
                    set_square_sum = set_square_sum + 39'(x_sq);
                end else begin
                    set_dropped = 1'b1;
                end
                if (i_in_data.last) begin
                    expected_results.push_back(
                        finish_set(set_count, set_sum, set_square_sum, set_dropped));
                    set_count      = '0;
                    set_sum        = '0;
                    set_square_sum = '0;
                    set_dropped    = 1'b0;
                end
            end
        end
        o_outstanding <= expected_results.size();
        o_fail_count  <= mismatches;
    end

endmodule

/* verif/sample_standard_deviation_test.sv */
`timescale 1ns / 100ps

module sample_standard_deviation_test;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   outstanding;
    int   items_sent;
    logic rx_quiet;

    ssd_stream_if #(.T(ssd_pkg::t_in_item))  in_if ();
    ssd_stream_if #(.T(ssd_pkg::t_out_item)) out_if ();

    sample_standard_deviation dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    sample_standard_deviation_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_if.valid),
        .i_in_ready    (in_if.ready),
        .i_in_data     (in_if.data),
        .i_out_valid   (out_if.valid),
        .i_out_ready   (out_if.ready),
        .i_out_data    (out_if.data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("sample_standard_deviation_test: FAIL");
        $finish;
    end

    function automatic int pick_gap(input logic quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 70) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 50);
    endfunction

    function automatic logic signed [ssd_pkg::IN_BITS-1:0] random_sample();
        int r;
        r = $urandom_range(0, 9);
        unique case (r)
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(0, 4)) - 2);
            3, 4: return 16'(int'($urandom_range(0, 200)) - 100);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_sample(
        input logic signed [ssd_pkg::IN_BITS-1:0] value,
        input logic                               is_last,
        input int                                 gap
    );
        if (gap > 0) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_if.valid <= 1'b1;
        in_if.data  <= '{sample: value, last: is_last};
        do @(posedge i_clk); while (!in_if.ready);
        items_sent++;
    endtask

    task automatic send_constant_set(input logic signed [ssd_pkg::IN_BITS-1:0] value,
                                     input int len);
        for (int i = 0; i < len; i++) begin
            send_sample(value, i == len - 1, pick_gap(1'b0));
        end
    endtask

    // receiver back-pressure
    initial begin
        int stall_left;
        int r;
        stall_left   = 0;
        rx_quiet     = 1'b0;
        out_if.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 299) == 0) begin
                rx_quiet = ~rx_quiet;
            end
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
                r = $urandom_range(0, 99);
                if (!rx_quiet) begin
                    if (r >= 97) begin
                        stall_left = $urandom_range(20, 120);
                    end else if (r >= 80) begin
                        stall_left = $urandom_range(1, 4);
                    end
                end
            end
        end
    end

    initial begin
        int   len;
        int   r;
        logic quiet;
        items_sent  = 0;
        i_rst_n     = 1'b0;
        in_if.valid = 1'b0;
        in_if.data  = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single samples, widest pair, flat sets, small spread
        send_sample(16'sh7fff, 1'b1, 0);
        send_sample(16'sh8000, 1'b1, 0);
        send_sample(16'sh8000, 1'b0, 0);
        send_sample(16'sh7fff, 1'b1, 0);
        send_sample(16'sh0000, 1'b0, 1);
        send_sample(16'sh0000, 1'b1, 0);
        send_sample(-16'sd1, 1'b0, 0);
        send_sample(16'sh0000, 1'b0, 0);
        send_sample(16'sd1, 1'b1, 2);
        send_constant_set(16'sh7fff, 4);
        send_constant_set(16'sh8000, 5);
        send_sample(16'sh5555, 1'b0, 0);
        send_sample(16'shaaaa, 1'b1, 0);

        // full set without drops, then a set whose last three items are dropped
        for (int i = 0; i < 255; i++) begin
            send_sample(i[0] ? 16'sh7fff : 16'sh8000, i == 254, pick_gap(1'b1));
        end
        for (int i = 0; i < 258; i++) begin
            send_sample(i[0] ? 16'sh8000 : 16'sh7fff, i == 257, pick_gap(1'b1));
        end

        // hold off until the back end has drained
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);

        while (items_sent < 1750) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                len = $urandom_range(1, 8);
            end else if (r < 93) begin
                len = $urandom_range(9, 40);
            end else if (r < 98) begin
                len = $urandom_range(41, 254);
            end else begin
                len = $urandom_range(255, 290);
            end
            quiet = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++) begin
                send_sample(random_sample(), i == len - 1, pick_gap(quiet));
            end
        end

        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);

        if (fail_count == 0 && outstanding == 0) begin
            $display("sample_standard_deviation_test: PASS");
        end else begin
            $display("sample_standard_deviation_test: FAIL");
        end
        $finish;
    end

endmodule
